// ===== design/pdes_pkg.sv =====
// Package for the particle drag Euler step block.
// Holds fixed-point widths, register indexes and reset values; no dependencies.
package pdes_pkg;
  localparam int WordW = 32;
  localparam int FracBitsDef = 16;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INV_MASS = 3'd0,
    REG_TIME_STEP = 3'd1,
    REG_GRAVITY = 3'd2,
    REG_DRAG = 3'd3,
    REG_WIND = 3'd4
  } reg_idx_t;

  localparam logic [WordW-1:0] TimeStep16 = 32'd655;
  localparam logic [WordW-1:0] Gravity16Mag = 32'd642253;
endpackage

// ===== design/pdes_if.sv =====
// Valid/ready channel interfaces for the particle drag Euler step block.
// Depends on pdes_pkg.
interface pdes_in_if;
  logic valid;
  logic ready;
  logic collision;
  logic signed [31:0] impact_force_x;
  logic signed [31:0] impact_force_y;
  modport source(output valid, collision, impact_force_x, impact_force_y, input ready);
  modport sink(input valid, collision, impact_force_x, impact_force_y, output ready);
endinterface

interface pdes_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] position_x;
  logic signed [31:0] position_y;
  logic signed [31:0] velocity_x;
  logic signed [31:0] velocity_y;
  logic [31:0] speed_out;
  modport source(output valid, position_x, position_y, velocity_x, velocity_y, speed_out,
                 input ready);
  modport sink(input valid, position_x, position_y, velocity_x, velocity_y, speed_out,
               output ready);
endinterface

interface pdes_cfg_if;
  logic valid;
  logic ready;
  logic [pdes_pkg::CfgIdxW-1:0] index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== design/particle_drag_euler_step_top.sv =====
// Particle drag Euler step: one shared 33x32 multiplier and one adder under a sequencer.
// From the input transaction to result valid: 9 multiply/add steps (6 on collision),
// 2 squaring steps and 32 square-root steps, one after another.
// A new transaction is taken only after the previous result is taken, since the steps run
// one at a time on the shared multiplier and the bit-pair square-root loop.
// The result register holds until taken, and the input is not ready meanwhile.
// Reset (rst, synchronous): state zeroed, registers to their defaults, output empty.
// Depends on pdes_pkg and pdes_if.
module particle_drag_euler_step_top #(
  parameter int FRAC_BITS = pdes_pkg::FracBitsDef
) (
  input logic clk,
  input logic rst,
  pdes_in_if.sink in_ch,
  pdes_out_if.source out_ch,
  pdes_cfg_if.sink cfg
);
  localparam int W = pdes_pkg::WordW;
  localparam logic signed [W-1:0] SMax = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMin = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_K, S_DX, S_DY, S_AX, S_AY, S_VX, S_VY, S_PX, S_PY, S_SQX, S_SQY, S_ROOT, S_OUT
  } state_t;

  state_t state;
  logic [W-1:0] inv_mass, time_step, drag_factor;
  logic signed [W-1:0] gravity, wind;
  logic signed [W-1:0] pos_x, pos_y, vel_x, vel_y;
  logic [W-1:0] speed_reg;
  logic signed [W-1:0] fx, fy, ax, ay;
  logic [W-1:0] kreg;
  logic [2*W-1:0] sq, rem_n, root;
  logic [4:0] iter;

  // Shared multiplier operands: signed 33-bit a times unsigned 32-bit b.
  logic signed [W:0] mul_a;
  logic [W-1:0] mul_b;
  logic mul_neg;
  logic signed [2*W+1:0] prod;
  logic signed [2*W+1:0] rnd;
  logic signed [2*W+1:0] shr;
  logic signed [W-1:0] mul_sat;
  logic [W-1:0] mul_usat;
  logic signed [W-1:0] add_a;
  logic signed [W+1:0] add_sum;
  logic signed [W-1:0] add_sat;

  // Squares go through the shared multiplier as magnitude times magnitude.
  logic [2*W-1:0] sq_term;
  logic signed [W-1:0] sq_src;
  logic [W-1:0] sq_abs;
  assign sq_src = (state == S_SQX) ? vel_x : vel_y;
  assign sq_abs = sq_src[W-1] ? (~sq_src + 1'b1) : sq_src;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_neg = 1'b0;
    add_a = '0;
    unique case (state)
      S_K: begin mul_a = $signed({1'b0, drag_factor}); mul_b = speed_reg; end
      S_DX: begin mul_a = (W+1)'(vel_x); mul_b = kreg; mul_neg = 1'b1; add_a = wind; end
      S_DY: begin mul_a = (W+1)'(vel_y); mul_b = kreg; mul_neg = 1'b1; add_a = gravity; end
      S_AX: begin mul_a = (W+1)'(fx); mul_b = inv_mass; end
      S_AY: begin mul_a = (W+1)'(fy); mul_b = inv_mass; end
      S_VX: begin mul_a = (W+1)'(ax); mul_b = time_step; add_a = vel_x; end
      S_VY: begin mul_a = (W+1)'(ay); mul_b = time_step; add_a = vel_y; end
      S_PX: begin mul_a = (W+1)'(vel_x); mul_b = time_step; add_a = pos_x; end
      S_PY: begin mul_a = (W+1)'(vel_y); mul_b = time_step; add_a = pos_y; end
      S_SQX, S_SQY: begin mul_a = $signed({1'b0, sq_abs}); mul_b = sq_abs; end
      default: ;
    endcase
    prod = (2*W+2)'(mul_a) * $signed({2'b0, mul_b});
    if (mul_neg) prod = -prod;
    // Round half up, then floor shift; the arithmetic shift floors negative values too.
    rnd = prod + ((2*W+2)'(1) <<< (FRAC_BITS - 1));
    shr = rnd >>> FRAC_BITS;
    if (shr > (2*W+2)'(SMax)) mul_sat = SMax;
    else if (shr < (2*W+2)'(SMin)) mul_sat = SMin;
    else mul_sat = shr[W-1:0];
    if (shr > (2*W+2)'({1'b0, {W{1'b1}}})) mul_usat = '1;
    else mul_usat = shr[W-1:0];
    add_sum = (W+2)'(add_a) + (W+2)'(mul_sat);
    if (add_sum > (W+2)'(SMax)) add_sat = SMax;
    else if (add_sum < (W+2)'(SMin)) add_sat = SMin;
    else add_sat = add_sum[W-1:0];
  end

  assign sq_term = prod[2*W-1:0];

  // One restoring square-root step per cycle over bit pairs.
  logic [2*W-1:0] bitv, trial, root_nx;
  assign bitv = (2*W)'(1) << {iter, 1'b0};
  assign trial = root + bitv;
  assign root_nx = (rem_n >= trial) ? (root >> 1) + bitv : root >> 1;

  assign in_ch.ready = (state == S_IDLE) && !rst;
  assign cfg.ready = 1'b1;
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.position_x = pos_x;
  assign out_ch.position_y = pos_y;
  assign out_ch.velocity_x = vel_x;
  assign out_ch.velocity_y = vel_y;
  assign out_ch.speed_out = speed_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      inv_mass <= W'(64'd1 << FRAC_BITS);
      time_step <= W'((64'(pdes_pkg::TimeStep16) << FRAC_BITS) >> 16);
      gravity <= -$signed(W'((64'(pdes_pkg::Gravity16Mag) << FRAC_BITS) >> 16));
      drag_factor <= '0;
      wind <= '0;
      pos_x <= '0; pos_y <= '0; vel_x <= '0; vel_y <= '0; speed_reg <= '0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          pdes_pkg::REG_INV_MASS: inv_mass <= cfg.data;
          pdes_pkg::REG_TIME_STEP: time_step <= cfg.data;
          pdes_pkg::REG_GRAVITY: gravity <= cfg.data;
          pdes_pkg::REG_DRAG: drag_factor <= cfg.data;
          pdes_pkg::REG_WIND: wind <= cfg.data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          fx <= in_ch.impact_force_x;
          fy <= in_ch.impact_force_y;
          state <= in_ch.collision ? S_AX : S_K;
        end
        S_K: begin kreg <= mul_usat; state <= S_DX; end
        S_DX: begin fx <= add_sat; state <= S_DY; end
        S_DY: begin fy <= add_sat; state <= S_AX; end
        S_AX: begin ax <= mul_sat; state <= S_AY; end
        S_AY: begin ay <= mul_sat; state <= S_VX; end
        S_VX: begin vel_x <= add_sat; state <= S_VY; end
        S_VY: begin vel_y <= add_sat; state <= S_PX; end
        S_PX: begin pos_x <= add_sat; state <= S_PY; end
        S_PY: begin pos_y <= add_sat; state <= S_SQX; end
        S_SQX: begin sq <= sq_term; state <= S_SQY; end
        S_SQY: begin
          rem_n <= sq + sq_term;
          root <= '0;
          iter <= 5'd31;
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (rem_n >= trial) rem_n <= rem_n - trial;
          root <= root_nx;
          if (iter == 5'd0) begin
            speed_reg <= root_nx[W-1:0];
            state <= S_OUT;
          end else begin
            iter <= iter - 5'd1;
          end
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) in_ch.ready |-> !out_ch.valid)
    else $error("input ready while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT && iter == 5'd0) |=> out_ch.valid)
    else $error("square root did not finish into output");
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.position_x) && $stable(out_ch.velocity_y))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_ch.valid && in_ch.collision) |=> state == S_AX)
    else $error("collision did not skip drag");
endmodule
